// ===== src/tcti_pkg.sv =====
// Shared types, constants and merge functions for the TSV column type inference block.
package tcti_pkg;

  localparam int MaxCols       = 32;
  localparam int ColIdxW       = $clog2(MaxCols);
  localparam int ColCntW       = $clog2(MaxCols + 1);
  localparam int MaxValueWidth = 4096;
  localparam int WidthW        = 13;
  localparam int DecW          = 12;
  localparam int DecLimit      = (2 ** DecW) - 1;

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharTab  = 8'h09;
  localparam logic [7:0] CharNl   = 8'h0A;
  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  typedef enum logic [1:0] {
    KIND_INT = 2'd0,
    KIND_DBL = 2'd1,
    KIND_STR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_HEADER   = 2'd0,
    STAT_MERGED   = 2'd1,
    STAT_MISMATCH = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [WidthW-1:0]  width;
    logic [DecW-1:0]    decimals;
  } col_entry_t;

  // Row store write request and row status from the byte scanner
  typedef struct packed {
    logic                store_we;
    logic [ColIdxW-1:0]  store_addr;
    col_entry_t          store_data;
    logic [ColCntW-1:0]  col_count;
    logic                overflow;
  } scan_t;

  function automatic col_entry_t merge_entry(col_entry_t s, col_entry_t c);
    col_entry_t r;
    r = s;
    if (c.width > s.width) r.width = c.width;
    if (c.kind == KIND_STR) begin
      r.kind = KIND_STR;
    end else if (c.kind == KIND_DBL) begin
      if (s.kind == KIND_INT) begin
        r.kind     = KIND_DBL;
        r.decimals = c.decimals;
      end else if (s.kind == KIND_DBL && c.decimals > s.decimals) begin
        r.decimals = c.decimals;
      end
    end
    return r;
  endfunction

  // All-empty column shows as string of width 1
  function automatic col_entry_t display_entry(col_entry_t s);
    col_entry_t r;
    r = s;
    if (s.kind != KIND_DBL) r.decimals = '0;
    if (s.width == '0) begin
      r.kind     = KIND_STR;
      r.width    = WidthW'(1);
      r.decimals = '0;
    end
    return r;
  endfunction

endpackage

// ===== src/tcti_scan.sv =====
// Byte scanner: classifies the current value and tracks the column position of the row.
module tcti_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         data_byte_i,
  output tcti_pkg::scan_t    scan_o
);
  import tcti_pkg::*;

  logic [ColCntW-1:0] col_q, col_d;
  kind_e              kind_q, kind_d;
  logic [WidthW-1:0]  width_q, width_d;
  logic [DecW-1:0]    dec_q, dec_d;
  logic               ovf_q, ovf_d;

  logic is_nul, is_tab, is_nl, is_digit, is_dot;
  logic [ColCntW-1:0] col_next;

  assign is_nul   = (data_byte_i == CharNul);
  assign is_tab   = (data_byte_i == CharTab);
  assign is_nl    = (data_byte_i == CharNl);
  assign is_dot   = (data_byte_i == CharDot);
  assign is_digit = (data_byte_i >= CharZero) && (data_byte_i <= CharNine);
  assign col_next = col_q + ColCntW'(1);

  always_comb begin
    col_d   = col_q;
    kind_d  = kind_q;
    width_d = width_q;
    dec_d   = dec_q;
    ovf_d   = ovf_q;
    if (byte_valid_i && !is_nul) begin
      if (is_nl) begin
        col_d   = '0;
        ovf_d   = 1'b0;
        kind_d  = KIND_INT;
        width_d = '0;
        dec_d   = '0;
      end else if (is_tab) begin
        if (!ovf_q) begin
          if (col_next < ColCntW'(MaxCols)) col_d = col_next;
          else ovf_d = 1'b1;
          kind_d  = KIND_INT;
          width_d = '0;
          dec_d   = '0;
        end
      end else begin
        if (width_q < WidthW'(MaxValueWidth)) width_d = width_q + WidthW'(1);
        if (is_digit) begin
          if (kind_q == KIND_DBL && dec_q < DecW'(DecLimit)) dec_d = dec_q + DecW'(1);
        end else if (kind_q == KIND_INT && is_dot) begin
          kind_d = KIND_DBL;
        end else begin
          kind_d = KIND_STR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      kind_q  <= KIND_INT;
      width_q <= '0;
      dec_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      kind_q  <= kind_d;
      width_q <= width_d;
      dec_q   <= dec_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    scan_o.store_we            = byte_valid_i && (is_nl || (is_tab && !ovf_q));
    scan_o.store_addr          = col_q[ColIdxW-1:0];
    scan_o.store_data.kind     = kind_q;
    scan_o.store_data.width    = width_q;
    scan_o.store_data.decimals = (kind_q == KIND_DBL) ? dec_q : '0;
    scan_o.col_count           = col_next;
    scan_o.overflow            = ovf_q;
  end

endmodule

// ===== src/tsv_column_type_inference.sv =====
// Top level of the TSV column type inference block: row store, schema table and emit sequencer.
//
// Input channel: one text byte per item on data_byte_i (in_valid_i/in_ready_o).
// Output channel: schema entries (out_valid_o/out_ready_i), one item per column.
// Ordinary bytes and tabs are taken one per cycle and give no result; NUL is dropped.
// At a newline the row is closed. An overflowing or mismatched row gives one status
// item in the next cycle. A header row or a matching data row starts a sweep over the
// schema table: each column goes through a memory read, then merge, write back and
// load of the output register, and output stalls hold it there; the split into steps
// follows from the single read port of the schema and row memories. No byte is taken
// during a sweep; a newline also waits while an earlier result is still pending.
// last_of_row_o marks the final item of a row.
// When the receiver stalls, the sweep holds in its emit step and the output holds.
// Reset forgets the header: the next complete row without overflow becomes the header.
// Both memories need no clearing: every entry read was written earlier in the row
// or at the header sweep.
module tsv_column_type_inference (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  column_index_o,
  output logic [1:0]  column_kind_o,
  output logic [12:0] column_width_o,
  output logic [11:0] column_decimals_o,
  output logic [1:0]  row_status_o,
  output logic        last_of_row_o
);
  import tcti_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic               hdr_done_q;
  logic [ColCntW-1:0] expected_q;
  logic [ColIdxW-1:0] idx_q;
  logic               header_mode_q;

  logic               out_valid_q;
  logic [ColIdxW-1:0] out_index_q;
  col_entry_t         out_entry_q;
  status_e            out_status_q;
  logic               out_last_q;

  col_entry_t row_mem    [MaxCols];
  col_entry_t schema_mem [MaxCols];
  col_entry_t row_rd_q;
  col_entry_t schema_rd_q;

  scan_t      scan;
  logic       is_nl, in_accept, nl_accept, out_free, sweep_last, schema_we;
  col_entry_t new_entry, shown_entry;

  assign is_nl      = (data_byte_i == CharNl);
  assign in_ready_o = (state_q == ST_IDLE) && (!is_nl || !out_valid_q);
  assign in_accept  = in_valid_i && in_ready_o;
  assign nl_accept  = in_accept && is_nl;
  assign out_free   = !out_valid_q || out_ready_i;
  assign sweep_last = ((ColCntW'(idx_q) + ColCntW'(1)) == expected_q);
  assign schema_we  = (state_q == ST_EMIT) && out_free;

  tcti_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .data_byte_i  (data_byte_i),
    .scan_o       (scan)
  );

  always_comb begin
    if (header_mode_q) begin
      new_entry.kind     = KIND_INT;
      new_entry.width    = '0;
      new_entry.decimals = '0;
    end else begin
      new_entry = merge_entry(schema_rd_q, row_rd_q);
    end
    shown_entry = display_entry(new_entry);
  end

  always_ff @(posedge clk_i) begin
    if (scan.store_we) row_mem[scan.store_addr] <= scan.store_data;
    if (state_q == ST_READ) row_rd_q <= row_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (schema_we) schema_mem[idx_q] <= new_entry;
    if (state_q == ST_READ) schema_rd_q <= schema_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      hdr_done_q    <= 1'b0;
      expected_q    <= '0;
      idx_q         <= '0;
      header_mode_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_index_q   <= '0;
      out_entry_q   <= '0;
      out_status_q  <= STAT_HEADER;
      out_last_q    <= 1'b0;
    end else begin
      // drop the taken item unless the sweep loads the next one this cycle
      if (out_valid_q && out_ready_i && !schema_we) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (nl_accept) begin
            if (scan.overflow || (hdr_done_q && scan.col_count != expected_q)) begin
              out_valid_q  <= 1'b1;
              out_index_q  <= '0;
              out_entry_q  <= '0;
              out_status_q <= scan.overflow ? STAT_OVERFLOW : STAT_MISMATCH;
              out_last_q   <= 1'b1;
            end else begin
              if (!hdr_done_q) begin
                hdr_done_q <= 1'b1;
                expected_q <= scan.col_count;
              end
              header_mode_q <= !hdr_done_q;
              idx_q         <= '0;
              state_q       <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_index_q  <= idx_q;
            out_entry_q  <= shown_entry;
            out_status_q <= header_mode_q ? STAT_HEADER : STAT_MERGED;
            out_last_q   <= sweep_last;
            if (sweep_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + ColIdxW'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign column_index_o    = 5'(out_index_q);
  assign column_kind_o     = out_entry_q.kind;
  assign column_width_o    = out_entry_q.width;
  assign column_decimals_o = out_entry_q.decimals;
  assign row_status_o      = out_status_q;
  assign last_of_row_o     = out_last_q;

  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (state_q == ST_IDLE))
    else $error("byte taken outside idle");

  a_nl_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_accept |-> !out_valid_q)
    else $error("newline taken while a result is pending");

  a_ovf_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nl_accept && scan.overflow) |=>
      (out_valid_o && last_of_row_o && row_status_o == STAT_OVERFLOW))
    else $error("overflow row did not give its status item");

  a_sweep_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (ColCntW'(idx_q) < expected_q))
    else $error("sweep index beyond column count");

endmodule
